/* rtl/core/gbfo_pkg.sv */
package gbfo_pkg;

  // Field widths fixed by the item format.
  localparam int VertexW     = 4;
  localparam int RowW        = 16;
  localparam int CountW      = 5;
  localparam int RowLimit    = 16;
  localparam int MaxVertices = 16;

  // Operation codes.
  localparam logic OpLoad   = 1'b0;
  localparam logic OpSearch = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [VertexW-1:0] vertex;
    logic [RowW-1:0]    neighbour_bits;
  } in_t;

  typedef struct packed {
    logic [VertexW-1:0] visited_vertex;
    logic               last;
    logic               bad_start;
  } out_t;

  typedef enum logic [2:0] {
    StIdle,
    StDeq,
    StQWait,
    StRWait,
    StScan
  } state_e;

endpackage

/* rtl/core/graph_breadth_first_order.sv */
// Channel   | Direction | Ports                         | Transfer
// ----------+-----------+-------------------------------+----------------------------------
// command   | in        | start_i, busy_o, item_i       | edge with start_i high, busy_o low
// result    | out       | res_strobe_o, res_o           | every cycle res_strobe_o is high
// config    | in        | cfg_we_i, cfg_wdata_i         | edge with cfg_we_i high
//
// A load gives no result. A bad start gives its single result in the next
// cycle. A good search keeps busy_o high while each dequeued vertex passes
// through dequeue, queue RAM read, adjacency RAM read and empty scan, plus one
// scan step per new vertex it adds, and one more dequeue finds the queue empty.
// The final result shows in the same cycle that busy_o falls. Reset clears the
// adjacency rows at once through per-row valid bits; no clearing pass. The
// receiver cannot stall: each result is shown for exactly one cycle.
module graph_breadth_first_order #(
  parameter int MaxVertices = gbfo_pkg::MaxVertices
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  gbfo_pkg::in_t                     item_i,
  input  logic                              cfg_we_i,
  input  logic [gbfo_pkg::CountW-1:0]       cfg_wdata_i,
  output logic                              res_strobe_o,
  output gbfo_pkg::out_t                    res_o
);

  // Rows at or above the lesser of the two limits are never stored.
  localparam int RowDepth = (MaxVertices < gbfo_pkg::RowLimit) ? MaxVertices
                                                                 : gbfo_pkg::RowLimit;
  localparam int RowAw    = $clog2(RowDepth);
  localparam int QAw      = $clog2(MaxVertices);

  localparam int VW = gbfo_pkg::VertexW;
  localparam int RW = gbfo_pkg::RowW;
  localparam int CW = gbfo_pkg::CountW;

  gbfo_pkg::state_e state_q, state_d;

  logic [CW-1:0]       vcount_q;
  logic [RowDepth-1:0] row_valid_q, row_valid_d;
  logic [RW-1:0]       visited_q, visited_d;
  logic [RW-1:0]       cand_q, cand_d;
  logic [QAw-1:0]      head_q, head_d, tail_q, tail_d;
  logic [VW-1:0]       pend_q, pend_d;
  logic                row_vld_q;
  logic                res_strobe_q, res_strobe_d;
  gbfo_pkg::out_t      res_q, res_d;

  logic [CW-1:0]       n_act;
  logic [RW-1:0]       mask;
  logic [VW-1:0]       pick;
  logic [RW-1:0]       row_eff;

  // Queue RAM port signals
  logic                q_we;
  logic [QAw-1:0]      q_waddr;
  logic [VW-1:0]       q_wdata;
  logic [VW-1:0]       q_rdata;

  // Adjacency RAM port signals
  logic                a_we;
  logic [RowAw-1:0]    a_waddr;
  logic [RW-1:0]       a_rdata;
  logic [RowAw-1:0]    a_raddr;

  gbfo_ram #(
    .Width (VW),
    .Depth (MaxVertices)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (head_q),
    .rdata_o (q_rdata)
  );

  gbfo_ram #(
    .Width (RW),
    .Depth (RowDepth)
  ) u_adj (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (item_i.neighbour_bits),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  // Dequeued vertex addresses its row straight from the queue read data.
  assign a_raddr = q_rdata[RowAw-1:0];
  assign a_waddr = item_i.vertex[RowAw-1:0];

  // Vertex count saturates at RowDepth, the lesser of the two limits.
  assign n_act = (vcount_q > CW'(RowDepth)) ? CW'(RowDepth) : vcount_q;

  always_comb begin
    for (int j = 0; j < RW; j++) begin
      mask[j] = (CW'(j) < n_act);
    end
  end

  assign row_eff = (row_vld_q ? a_rdata : '0) & mask & ~visited_q;

  // Lowest pending neighbour first: ascending index order.
  always_comb begin
    pick = '0;
    for (int j = RW - 1; j >= 0; j--) begin
      if (cand_q[j]) begin
        pick = VW'(j);
      end
    end
  end

  assign busy_o = (state_q != gbfo_pkg::StIdle);

  always_comb begin
    state_d      = state_q;
    row_valid_d  = row_valid_q;
    visited_d    = visited_q;
    cand_d       = cand_q;
    head_d       = head_q;
    tail_d       = tail_q;
    pend_d       = pend_q;
    res_strobe_d = 1'b0;
    res_d        = res_q;
    q_we         = 1'b0;
    q_waddr      = tail_q;
    q_wdata      = pick;
    a_we         = 1'b0;

    case (state_q)
      gbfo_pkg::StIdle: begin
        if (start_i) begin
          if (item_i.operation == gbfo_pkg::OpLoad) begin
            if ({1'b0, item_i.vertex} < CW'(RowDepth)) begin
              a_we                               = 1'b1;
              row_valid_d[item_i.vertex[RowAw-1:0]] = 1'b1;
            end
          end else if ({1'b0, item_i.vertex} >= n_act) begin
            res_strobe_d         = 1'b1;
            res_d.visited_vertex = '0;
            res_d.last           = 1'b1;
            res_d.bad_start      = 1'b1;
          end else begin
            // Start vertex goes in slot 0 and is held back until the next
            // vertex shows whether it is the final one.
            visited_d               = '0;
            visited_d[item_i.vertex] = 1'b1;
            q_we                    = 1'b1;
            q_waddr                 = '0;
            q_wdata                 = item_i.vertex;
            head_d                  = '0;
            tail_d                  = QAw'(1);
            pend_d                  = item_i.vertex;
            state_d                 = gbfo_pkg::StDeq;
          end
        end
      end

      gbfo_pkg::StDeq: begin
        if (head_q == tail_q) begin
          res_strobe_d         = 1'b1;
          res_d.visited_vertex = pend_q;
          res_d.last           = 1'b1;
          res_d.bad_start      = 1'b0;
          state_d              = gbfo_pkg::StIdle;
        end else begin
          head_d  = (head_q == QAw'(MaxVertices - 1)) ? '0 : head_q + 1'b1;
          state_d = gbfo_pkg::StQWait;
        end
      end

      gbfo_pkg::StQWait: begin
        state_d = gbfo_pkg::StRWait;
      end

      gbfo_pkg::StRWait: begin
        cand_d  = row_eff;
        state_d = gbfo_pkg::StScan;
      end

      gbfo_pkg::StScan: begin
        if (cand_q == '0) begin
          state_d = gbfo_pkg::StDeq;
        end else begin
          res_strobe_d         = 1'b1;
          res_d.visited_vertex = pend_q;
          res_d.last           = 1'b0;
          res_d.bad_start      = 1'b0;
          pend_d               = pick;
          visited_d[pick]      = 1'b1;
          cand_d[pick]         = 1'b0;
          q_we                 = 1'b1;
          tail_d = (tail_q == QAw'(MaxVertices - 1)) ? '0 : tail_q + 1'b1;
        end
      end

      default: begin
        state_d = gbfo_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= gbfo_pkg::StIdle;
      vcount_q     <= CW'(gbfo_pkg::RowLimit);
      row_valid_q  <= '0;
      visited_q    <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      res_strobe_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      row_valid_q  <= row_valid_d;
      visited_q    <= visited_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      res_strobe_q <= res_strobe_d;
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q    <= cand_d;
    pend_q    <= pend_d;
    res_q     <= res_d;
    row_vld_q <= row_valid_q[q_rdata[RowAw-1:0]];
  end

  assign res_strobe_o = res_strobe_q;
  assign res_o        = res_q;

  // A bad start is always a single, final result.
  a_bad_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && res_o.bad_start |-> res_o.last)
    else $error("bad start result without last");

  // Non-final results only come out while a search is still running.
  a_nonlast_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !res_o.last |-> busy_o)
    else $error("non-final result outside a search");

  // Each scanned neighbour is new; a vertex is never enqueued twice.
  a_pick_unvisited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gbfo_pkg::StScan) && (cand_q != '0) |-> !visited_q[pick])
    else $error("revisiting a vertex");

  // A search only begins on an accepted search command.
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i && item_i.operation == gbfo_pkg::OpSearch))
    else $error("search started without command");

endmodule

/* rtl/core/gbfo_ram.sv */
module gbfo_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
